// ===== hw/rtl/sbte_pkg.sv =====
package sbte_pkg;

  localparam logic [1:0] FUNC_REQ  = 2'd0;
  localparam logic [1:0] FUNC_BYTE = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  localparam logic KIND_TX  = 1'b0;
  localparam logic KIND_CPL = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CHKSUM  = 2'd1;
  localparam logic [1:0] ST_WRONGID = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  localparam logic [7:0] HDR_BYTE  = 8'hFF;
  localparam logic [7:0] INS_READ  = 8'h02;
  localparam logic [7:0] INS_WRITE = 8'h03;

  localparam logic [15:0] TIMEOUT_RESET = 16'd5;
  localparam int unsigned PKT_MAX       = 9;
  localparam int unsigned PKT_IDX_W     = $clog2(PKT_MAX + 1);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_HDR1  = 4'd1,
    PH_HDR2  = 4'd2,
    PH_ID    = 4'd3,
    PH_LEN   = 4'd4,
    PH_ERR   = 4'd5,
    PH_PARAM = 4'd6,
    PH_CHK   = 4'd7
  } phase_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  servo_id;
    logic        is_read;
    logic        wide;
    logic [7:0]  reg_addr;
    logic [15:0] write_value;
    logic [7:0]  rx_byte;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [1:0]  status;
    logic [7:0]  servo_error;
    logic [15:0] read_value;
  } res_t;

endpackage

// ===== hw/rtl/sbte_chan_if.sv =====
interface sbte_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/servo_bus_transaction_engine.sv =====
// channel   direction  payload                                      handshake
// req       sink       func servo_id is_read wide reg_addr ...       valid/ready
// res       source     kind tx_byte last status servo_error ...      valid/ready
// cfg       write      timeout_ticks (16 bits)                       cfg_wen
//
// A request yields 8 or 9 transmit bytes, one per cycle while res is ready.
// A received byte or tick yields zero or one completion.
// Any input is taken once the result buffer is empty, or holds only its last result
// and that result leaves in the same cycle; bytes and ticks run back to back while res is ready.
// Reset (rst, synchronous) clears the phase, reply state, buffer and timeout (5).
module servo_bus_transaction_engine import sbte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  sbte_chan_if.sink   req,
  sbte_chan_if.source res
);

  logic [15:0] timeout_ticks;
  phase_t      phase, phase_next;
  logic [7:0]  expected_id, expected_id_next;
  logic [7:0]  reply_id, reply_id_next;
  logic [7:0]  reply_length, reply_length_next;
  logic [7:0]  reply_error, reply_error_next;
  logic [7:0]  param_low, param_low_next;
  logic [7:0]  param_high, param_high_next;
  logic [7:0]  param_count, param_count_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] wait_ticks, wait_ticks_next;

  logic [PKT_IDX_W-1:0] pend_left;
  logic [PKT_IDX_W-1:0] pos;
  logic                 pend_cpl;
  logic [7:0]           pkt [PKT_MAX];
  logic [1:0]           cpl_status;
  logic [7:0]           cpl_error;
  logic [15:0]          cpl_value;

  logic                 req_fire;
  logic                 res_fire;
  logic [PKT_IDX_W-1:0] gen_count;
  logic                 gen_cpl;
  logic [1:0]           gen_status;
  logic [7:0]           gen_error;
  logic [15:0]          gen_value;
  logic [7:0]           gen_pkt [PKT_MAX];

  logic       three_params;
  logic [7:0] req_len, req_ins, req_p1, req_p2, req_sum, req_chk;
  logic [7:0] params_exp;
  logic [7:0] count_inc;

  function automatic logic req_chk_mismatch(input logic [7:0] sum, input logic [7:0] b);
    return (~sum) != b;
  endfunction

  assign res_fire  = res.valid && res.ready;
  assign req.ready = (pend_left == '0) ||
                     ((pend_left == PKT_IDX_W'(1)) && res.ready);
  assign req_fire  = req.valid && req.ready;

  // request packet
  assign three_params = !req.data.is_read && req.data.wide;
  assign req_len = three_params ? 8'd5 : 8'd4;
  assign req_ins = req.data.is_read ? INS_READ : INS_WRITE;
  assign req_p1  = req.data.is_read ? (req.data.wide ? 8'd2 : 8'd1)
                                    : req.data.write_value[7:0];
  assign req_p2  = three_params ? req.data.write_value[15:8] : 8'd0;
  assign req_sum = req.data.servo_id + req_len + req_ins + req.data.reg_addr
                 + req_p1 + req_p2;
  assign req_chk = ~req_sum;

  assign params_exp = (reply_length > 8'd2) ? (reply_length - 8'd2) : 8'd0;
  assign count_inc  = param_count + 8'd1;

  // next state
  always_comb begin
    phase_next        = phase;
    expected_id_next  = expected_id;
    reply_id_next     = reply_id;
    reply_length_next = reply_length;
    reply_error_next  = reply_error;
    param_low_next    = param_low;
    param_high_next   = param_high;
    param_count_next  = param_count;
    running_sum_next  = running_sum;
    wait_ticks_next   = wait_ticks;
    if (req_fire) begin
      case (req.data.func)
        FUNC_REQ: begin
          expected_id_next  = req.data.servo_id;
          reply_id_next     = 8'd0;
          reply_length_next = 8'd0;
          reply_error_next  = 8'd0;
          param_low_next    = 8'd0;
          param_high_next   = 8'd0;
          param_count_next  = 8'd0;
          running_sum_next  = 8'd0;
          wait_ticks_next   = 16'd0;
          phase_next        = PH_HDR1;
        end
        FUNC_BYTE: begin
          case (phase)
            PH_HDR1: begin
              if (req.data.rx_byte == HDR_BYTE) phase_next = PH_HDR2;
            end
            PH_HDR2: begin
              phase_next = (req.data.rx_byte == HDR_BYTE) ? PH_ID : PH_HDR1;
            end
            PH_ID: begin
              reply_id_next    = req.data.rx_byte;
              running_sum_next = req.data.rx_byte;
              phase_next       = PH_LEN;
            end
            PH_LEN: begin
              reply_length_next = req.data.rx_byte;
              running_sum_next  = running_sum + req.data.rx_byte;
              phase_next        = PH_ERR;
            end
            PH_ERR: begin
              reply_error_next = req.data.rx_byte;
              running_sum_next = running_sum + req.data.rx_byte;
              param_count_next = 8'd0;
              param_low_next   = 8'd0;
              param_high_next  = 8'd0;
              phase_next       = (params_exp != 8'd0) ? PH_PARAM : PH_CHK;
            end
            PH_PARAM: begin
              if (param_count == 8'd0) param_low_next = req.data.rx_byte;
              else if (param_count == 8'd1) param_high_next = req.data.rx_byte;
              running_sum_next = running_sum + req.data.rx_byte;
              param_count_next = count_inc;
              if (count_inc >= params_exp) phase_next = PH_CHK;
            end
            PH_CHK: begin
              phase_next = PH_IDLE;
            end
            default: begin
            end
          endcase
        end
        FUNC_TICK: begin
          if (phase != PH_IDLE) begin
            if (wait_ticks >= timeout_ticks) phase_next = PH_IDLE;
            else wait_ticks_next = wait_ticks + 16'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // results
  always_comb begin
    gen_count  = '0;
    gen_cpl    = 1'b0;
    gen_status = ST_OK;
    gen_error  = 8'd0;
    gen_value  = 16'd0;
    gen_pkt[0] = HDR_BYTE;
    gen_pkt[1] = HDR_BYTE;
    gen_pkt[2] = req.data.servo_id;
    gen_pkt[3] = req_len;
    gen_pkt[4] = req_ins;
    gen_pkt[5] = req.data.reg_addr;
    gen_pkt[6] = req_p1;
    gen_pkt[7] = three_params ? req_p2 : req_chk;
    gen_pkt[8] = req_chk;
    if (req_fire) begin
      case (req.data.func)
        FUNC_REQ: begin
          gen_count = three_params ? PKT_IDX_W'(9) : PKT_IDX_W'(8);
        end
        FUNC_BYTE: begin
          if (phase == PH_CHK) begin
            gen_count = PKT_IDX_W'(1);
            gen_cpl   = 1'b1;
            if (req_chk_mismatch(running_sum, req.data.rx_byte)) begin
              gen_status = ST_CHKSUM;
            end else if (reply_id != expected_id) begin
              gen_status = ST_WRONGID;
            end else begin
              gen_error = reply_error;
              gen_value = {param_high, param_low};
            end
          end
        end
        FUNC_TICK: begin
          if (phase != PH_IDLE && wait_ticks >= timeout_ticks) begin
            gen_count  = PKT_IDX_W'(1);
            gen_cpl    = 1'b1;
            gen_status = ST_TIMEOUT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      phase         <= PH_IDLE;
      expected_id   <= 8'd0;
      reply_id      <= 8'd0;
      reply_length  <= 8'd0;
      reply_error   <= 8'd0;
      param_low     <= 8'd0;
      param_high    <= 8'd0;
      param_count   <= 8'd0;
      running_sum   <= 8'd0;
      wait_ticks    <= 16'd0;
      pend_left     <= '0;
      pos           <= '0;
      pend_cpl      <= 1'b0;
    end else begin
      if (cfg_wen) timeout_ticks <= cfg_wdata;
      phase        <= phase_next;
      expected_id  <= expected_id_next;
      reply_id     <= reply_id_next;
      reply_length <= reply_length_next;
      reply_error  <= reply_error_next;
      param_low    <= param_low_next;
      param_high   <= param_high_next;
      param_count  <= param_count_next;
      running_sum  <= running_sum_next;
      wait_ticks   <= wait_ticks_next;
      if (gen_count != '0) begin
        pend_left <= gen_count;
        pos       <= '0;
        pend_cpl  <= gen_cpl;
      end else if (res_fire) begin
        pend_left <= pend_left - PKT_IDX_W'(1);
        if (pend_left != PKT_IDX_W'(1)) pos <= pos + PKT_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (gen_count != '0) begin
      if (gen_cpl) begin
        cpl_status <= gen_status;
        cpl_error  <= gen_error;
        cpl_value  <= gen_value;
      end else begin
        for (int i = 0; i < PKT_MAX; i++) pkt[i] <= gen_pkt[i];
      end
    end
  end

  always_comb begin
    res.valid            = (pend_left != '0);
    res.data.kind        = pend_cpl ? KIND_CPL : KIND_TX;
    res.data.tx_byte     = pend_cpl ? 8'd0 : pkt[pos];
    res.data.last        = !pend_cpl && (pend_left == PKT_IDX_W'(1));
    res.data.status      = pend_cpl ? cpl_status : ST_OK;
    res.data.servo_error = pend_cpl ? cpl_error : 8'd0;
    res.data.read_value  = pend_cpl ? cpl_value : 16'd0;
  end

endmodule
